// ----- rtl/srmt_pkg.sv -----
package srmt_pkg;
    localparam int DEPTH_DEF = 16;
    localparam int MAX_OUT = 16;
    localparam int ENTRY_W = 8 + 16 + 16 + 32 + 24;
    localparam logic [23:0] RATE_RST = 24'd16777;
    localparam logic [23:0] FLOOR_RST = 24'd655;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_KIND = 2'd1;
    localparam logic [1:0] OP_NEAR = 2'd2;
    localparam logic [1:0] OP_DECAY = 2'd3;

    localparam logic CFG_RATE = 1'b0;
    localparam logic CFG_FLOOR = 1'b1;

    typedef struct packed {
        logic [7:0]  kind;
        logic [15:0] x;
        logic [15:0] y;
        logic [31:0] stamp;
        logic [23:0] sig;
    } t_entry;
endpackage

// ----- rtl/srmt_ram.sv -----
module srmt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- rtl/significance_ranked_memory_table_top.sv -----
// Significance-ranked table of DEPTH entries held in one synchronous RAM. One command
// runs at a time. busy rises at the accepting edge and falls in the cycle that carries
// the final result word. Add reads every slot once and then writes. Decay makes the same
// read pass and then walks each slot through read, rate*age product, significance
// product and write back. A recall runs one selection pass (a read of every slot, then
// an emit) for each entry it emits, with at most min(max_count, DEPTH, 16) passes and
// at least one. The word of a pass comes in the first cycle after that pass. A pass
// also notes whether a second candidate remains, so last is known when the word leaves.
// Results come on o_valid for one cycle each and the receiver cannot stall them.
// Configuration writes are taken whenever i_cfg_valid is high. Issue them only while
// no command is in flight.
module significance_ranked_memory_table_top #(
    parameter int DEPTH = srmt_pkg::DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_opcode,
    input  logic [7:0]         i_mem_kind,
    input  logic signed [15:0] i_pos_x,
    input  logic signed [15:0] i_pos_y,
    input  logic [15:0]        i_search_radius,
    input  logic [31:0]        i_now_tick,
    input  logic [23:0]        i_new_significance,
    input  logic [4:0]         i_max_count,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [23:0]        i_cfg_data,
    output logic               o_valid,
    output logic               o_found,
    output logic               o_stored,
    output logic [7:0]         o_out_kind,
    output logic signed [15:0] o_out_x,
    output logic signed [15:0] o_out_y,
    output logic [31:0]        o_out_stamp,
    output logic [23:0]        o_out_significance,
    output logic               o_last
);
    import srmt_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int CAP_MAX = (DEPTH < MAX_OUT) ? DEPTH : MAX_OUT;

    typedef enum logic [7:0] {
        S_IDLE = 8'b00000001,
        S_SCAN = 8'b00000010,
        S_ADDW = 8'b00000100,
        S_DEC1 = 8'b00001000,
        S_DEC2 = 8'b00010000,
        S_DEC3 = 8'b00100000,
        S_DEC4 = 8'b01000000,
        S_EMIT = 8'b10000000
    } t_state;

    t_state r_state, n_state;

    logic [23:0] r_rate, r_floor;
    logic [DEPTH-1:0] r_valid, r_mark;
    logic [1:0]  r_op;
    logic [7:0]  r_kind;
    logic signed [15:0] r_qx, r_qy;
    logic [32:0] r_r2;
    logic [31:0] r_now;
    logic [23:0] r_nsig;
    logic [CW-1:0] r_cap, r_cnt;
    logic [AW:0] r_idx;          // read address of the scan, one extra count
    logic        r_rv;           // read data valid for r_ridx
    logic [AW-1:0] r_ridx;
    logic        r_have;
    logic        r_more;         // a second candidate was seen in this pass
    logic [AW-1:0] r_best;
    logic [32:0] r_bkey;
    t_entry      r_bent;
    logic        r_free_f;
    logic [AW-1:0] r_free;
    logic        r_add_ok;

    // RAM
    logic          ram_we;
    logic [AW-1:0] ram_wa, ram_ra;
    t_entry        ram_wd, ram_rd;

    srmt_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_wa),
        .i_wdata (ram_wd),
        .i_raddr (ram_ra),
        .o_rdata (ram_rd)
    );

    assign o_cfg_ready = 1'b1;
    assign busy = (r_state != S_IDLE);

    // Squared distance of the read entry to the query point
    logic signed [16:0] dx, dy;
    logic [33:0] d2;
    assign dx = 17'(signed'(ram_rd.x)) - 17'(r_qx);
    assign dy = 17'(signed'(ram_rd.y)) - 17'(r_qy);
    assign d2 = 34'(dx * dx) + 34'(dy * dy);

    // Decay pipeline: age, then rate*age, then sig*(2^24 - rate*age)
    logic [31:0] r_age;
    logic [23:0] r_dsig;
    logic [55:0] r_p;
    logic [47:0] r_sp;
    logic [AW-1:0] r_didx;
    t_entry r_dent;
    logic [23:0] dec_s;
    always_comb begin
        dec_s = (r_p >= 56'h1000000) ? 24'd0 : r_sp[47:24];
        if (dec_s < r_floor) dec_s = r_floor;
    end

    logic cand;
    logic [32:0] key;
    logic better;
    always_comb begin
        cand = r_rv && r_valid[r_ridx] && !r_mark[r_ridx];
        key = '0;
        better = 1'b0;
        if (r_op == OP_KIND) begin
            cand = cand && (ram_rd.kind == r_kind);
            key = {9'd0, ram_rd.sig};
            better = !r_have || key > r_bkey;
        end else begin
            cand = cand && ({1'b0, r_r2} >= d2);
            key = d2[32:0];
            better = !r_have || key < r_bkey;
        end
    end

    logic scan_done;
    assign scan_done = r_rv && (r_ridx == AW'(DEPTH - 1));

    always_comb begin
        n_state = r_state;
        ram_we = 1'b0;
        ram_wa = r_best;
        ram_wd = r_dent;
        ram_ra = r_idx[AW-1:0];
        case (r_state)
            S_IDLE: if (start) n_state = S_SCAN;
            S_SCAN: if (scan_done) begin
                // point the read at slot 0 for the decay walk
                ram_ra = '0;
                if (r_op == OP_ADD) n_state = S_ADDW;
                else if (r_op == OP_DECAY) n_state = S_DEC1;
                else n_state = S_EMIT;
            end
            S_ADDW: begin
                ram_we = r_add_ok;
                ram_wa = r_free_f ? r_free : r_best;
                ram_wd = '{kind: r_kind, x: r_qx, y: r_qy, stamp: r_now, sig: r_nsig};
                n_state = S_IDLE;
            end
            S_DEC1: n_state = S_DEC2;
            S_DEC2: n_state = S_DEC3;
            S_DEC3: n_state = S_DEC4;
            S_DEC4: begin
                // write back this slot and fetch the next one
                ram_we = r_valid[r_didx];
                ram_wa = r_didx;
                ram_wd = r_dent;
                ram_wd.sig = dec_s;
                ram_ra = r_didx + 1'b1;
                n_state = (r_didx == AW'(DEPTH - 1)) ? S_IDLE : S_DEC1;
            end
            S_EMIT: begin
                if (!r_have || !r_more || r_cnt + 1'b1 >= r_cap) n_state = S_IDLE;
                else n_state = S_SCAN;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rate <= RATE_RST;
            r_floor <= FLOOR_RST;
            r_valid <= '0;
            r_mark <= '0;
            r_rv <= 1'b0;
            r_cap <= '0;
            r_cnt <= '0;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            o_valid <= 1'b0;
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_RATE) r_rate <= i_cfg_data;
                else r_floor <= i_cfg_data;
            end
            case (r_state)
                S_IDLE: if (start) begin
                    r_op <= i_opcode;
                    r_kind <= i_mem_kind;
                    r_qx <= i_pos_x;
                    r_qy <= i_pos_y;
                    r_r2 <= 33'(32'(i_search_radius) * 32'(i_search_radius));
                    r_now <= i_now_tick;
                    r_nsig <= i_new_significance;
                    r_cap <= (i_max_count > 5'(CAP_MAX)) ? CW'(CAP_MAX) : CW'(i_max_count);
                    r_cnt <= '0;
                    r_mark <= '0;
                    r_idx <= '0;
                    r_rv <= 1'b0;
                    r_have <= 1'b0;
                    r_more <= 1'b0;
                    r_free_f <= 1'b0;
                end
                S_SCAN: begin
                    // advance the read address; data arrives in the next cycle
                    if (r_idx < (AW+1)'(DEPTH)) begin
                        r_idx <= r_idx + 1'b1;
                        r_rv <= 1'b1;
                        r_ridx <= r_idx[AW-1:0];
                    end else begin
                        r_rv <= 1'b0;
                    end
                    if (r_rv) begin
                        if (r_op == OP_ADD) begin
                            if (!r_valid[r_ridx] && !r_free_f) begin
                                r_free_f <= 1'b1;
                                r_free <= r_ridx;
                            end
                            if (!r_have || ram_rd.sig < r_bkey[23:0]) begin
                                r_have <= 1'b1;
                                r_best <= r_ridx;
                                r_bkey <= {9'd0, ram_rd.sig};
                            end
                        end else if (r_op != OP_DECAY) begin
                            if (cand && r_have) r_more <= 1'b1;
                            if (cand && better) begin
                                r_have <= 1'b1;
                                r_best <= r_ridx;
                                r_bkey <= key;
                                r_bent <= ram_rd;
                            end
                        end
                    end
                    if (scan_done) begin
                        r_rv <= 1'b0;
                        r_idx <= '0;
                        r_didx <= '0;
                        if (r_op == OP_KIND || r_op == OP_NEAR) begin
                            if (r_cap == '0) r_have <= 1'b0;
                        end
                    end
                    if (scan_done && r_op == OP_ADD) begin
                        // the last slot is still in flight: fold it into the decision
                        r_add_ok <= r_free_f || !r_valid[r_ridx] ||
                            ((r_have && ram_rd.sig < r_bkey[23:0]) ?
                             (r_nsig > ram_rd.sig) : (r_nsig > r_bkey[23:0]));
                    end
                end
                S_ADDW: begin
                    if (r_add_ok) r_valid[r_free_f ? r_free : r_best] <= 1'b1;
                    o_valid <= 1'b1;
                    o_found <= 1'b0;
                    o_stored <= r_add_ok;
                    {o_out_kind, o_out_x, o_out_y, o_out_stamp, o_out_significance} <= '0;
                    o_last <= 1'b1;
                end
                S_DEC1: begin
                    // ram_rd holds slot r_didx
                    r_age <= r_now - ram_rd.stamp;
                    r_dsig <= ram_rd.sig;
                    r_dent <= ram_rd;
                end
                S_DEC2: r_p <= 56'(r_rate) * 56'(r_age);
                S_DEC3: r_sp <= 48'(r_dsig) * 48'(25'(25'h1000000 - r_p[24:0]));
                S_DEC4: begin
                    r_didx <= r_didx + 1'b1;
                    if (r_didx == AW'(DEPTH - 1)) begin
                        o_valid <= 1'b1;
                        o_found <= 1'b0;
                        o_stored <= 1'b0;
                        {o_out_kind, o_out_x, o_out_y, o_out_stamp, o_out_significance} <= '0;
                        o_last <= 1'b1;
                    end
                end
                S_EMIT: begin
                    o_valid <= 1'b1;
                    o_stored <= 1'b0;
                    if (r_have) begin
                        r_mark[r_best] <= 1'b1;
                        r_cnt <= r_cnt + 1'b1;
                        o_found <= 1'b1;
                        o_out_kind <= r_bent.kind;
                        o_out_x <= r_bent.x;
                        o_out_y <= r_bent.y;
                        o_out_stamp <= r_bent.stamp;
                        o_out_significance <= r_bent.sig;
                        // last when the cap is hit or nothing else qualified this pass
                        o_last <= (r_cnt + 1'b1 >= r_cap) || !r_more;
                    end else begin
                        o_found <= 1'b0;
                        {o_out_kind, o_out_x, o_out_y, o_out_stamp, o_out_significance} <= '0;
                        o_last <= 1'b1;
                    end
                    r_have <= 1'b0;
                    r_more <= 1'b0;
                    r_idx <= '0;
                    r_rv <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    property p_one_word_per_item_single;
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (r_op == OP_ADD || r_op == OP_DECAY)) |-> o_last;
    endproperty
    a_single: assert property (p_one_word_per_item_single) else $error("multi word add/decay");

    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |=> !(o_valid && !o_last && $past(r_state == S_IDLE)))
        else $error("word while idle");

    a_cnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= r_cap) else $error("emitted beyond cap");
endmodule

// ----- dv/significance_ranked_memory_table_top_tb.sv -----
module significance_ranked_memory_table_top_tb;
    import srmt_pkg::*;

    localparam int SLOTS    = DEPTH_DEF;
    localparam int WDOG_MAX = 6000;  // longest silent stretch is a decay
    localparam int QUIET_MIN = 12;   // idle cycles before a register write

    // One pending stimulus word: either a command or a register write.
    typedef struct {
        bit          is_cfg;
        logic        cfg_idx;
        logic [23:0] cfg_val;
        logic [1:0]  op;
        logic [7:0]  kind;
        logic [15:0] px;
        logic [15:0] py;
        logic [15:0] radius;
        logic [31:0] tick;
        logic [23:0] sig;
        logic [4:0]  count;
    } t_cmd;

    // One result word as the table should emit it.
    typedef struct {
        logic        found;
        logic        stored;
        logic [7:0]  kind;
        logic [15:0] x;
        logic [15:0] y;
        logic [31:0] stamp;
        logic [23:0] sig;
        logic        last;
    } t_answer;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         i_opcode;
    logic [7:0]         i_mem_kind;
    logic signed [15:0] i_pos_x;
    logic signed [15:0] i_pos_y;
    logic [15:0]        i_search_radius;
    logic [31:0]        i_now_tick;
    logic [23:0]        i_new_significance;
    logic [4:0]         i_max_count;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic               i_cfg_index;
    logic [23:0]        i_cfg_data;
    logic               o_valid;
    logic               o_found;
    logic               o_stored;
    logic [7:0]         o_out_kind;
    logic signed [15:0] o_out_x;
    logic signed [15:0] o_out_y;
    logic [31:0]        o_out_stamp;
    logic [23:0]        o_out_significance;
    logic               o_last;

    significance_ranked_memory_table_top i_dut (.*);

    // Shadow copy of the table and its registers.
    logic [23:0] rate_q;
    logic [23:0] floor_q;
    bit          tbl_valid [SLOTS];
    logic [7:0]  tbl_kind  [SLOTS];
    logic [15:0] tbl_x     [SLOTS];
    logic [15:0] tbl_y     [SLOTS];
    logic [31:0] tbl_stamp [SLOTS];
    logic [23:0] tbl_sig   [SLOTS];

    t_cmd    pending_cmds[$];
    t_answer expected_words[$];
    t_cmd    cur_cmd;
    int      fails;
    int      quiet_cycles;
    int      stall_cycles;
    int      words_sent;
    logic [31:0] tick_now;

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    function automatic t_answer empty_answer(logic stored);
        t_answer a;
        a = '{default: '0};
        a.stored = stored;
        a.last = 1'b1;
        return a;
    endfunction

    function automatic longint dist_sq(int s, logic [15:0] qx, logic [15:0] qy);
        longint dx;
        longint dy;
        dx = longint'($signed(tbl_x[s])) - longint'($signed(qx));
        dy = longint'($signed(tbl_y[s])) - longint'($signed(qy));
        return dx * dx + dy * dy;
    endfunction

    // Advance the shadow table by one command and queue the words it must produce.
    function automatic void predict_table(t_cmd c);
        int      target;
        int      low;
        int      best;
        int      n;
        int      cap;
        longint  key;
        longint  bkey;
        longint  r2;
        bit      marked [SLOTS];
        logic [55:0] p;
        logic [47:0] prod;
        logic [23:0] s;
        logic [31:0] age;
        t_answer a;
        case (c.op)
            OP_ADD: begin
                target = -1;
                for (int i = 0; i < SLOTS; i++)
                    if (target < 0 && !tbl_valid[i]) target = i;
                if (target < 0) begin
                    low = 0;
                    for (int i = 1; i < SLOTS; i++)
                        if (tbl_sig[i] < tbl_sig[low]) low = i;
                    if (c.sig > tbl_sig[low]) target = low;
                end
                if (target >= 0) begin
                    tbl_valid[target] = 1'b1;
                    tbl_kind[target]  = c.kind;
                    tbl_x[target]     = c.px;
                    tbl_y[target]     = c.py;
                    tbl_stamp[target] = c.tick;
                    tbl_sig[target]   = c.sig;
                end
                expected_words = {expected_words, empty_answer(target >= 0)};
            end
            OP_DECAY: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (tbl_valid[i]) begin
                        age = c.tick - tbl_stamp[i];
                        p = 56'(rate_q) * 56'(age);
                        if (p >= 56'd16777216) begin
                            s = '0;
                        end else begin
                            prod = 48'(tbl_sig[i]) * 48'(56'd16777216 - p);
                            s = prod[47:24];
                        end
                        if (s < floor_q) s = floor_q;
                        tbl_sig[i] = s;
                    end
                end
                expected_words = {expected_words, empty_answer(1'b0)};
            end
            default: begin
                cap = (c.count > SLOTS) ? SLOTS : int'(c.count);
                if (cap > MAX_OUT) cap = MAX_OUT;
                r2 = longint'(c.radius) * longint'(c.radius);
                marked = '{default: 1'b0};
                n = 0;
                while (n < cap) begin
                    best = -1;
                    bkey = 0;
                    for (int i = 0; i < SLOTS; i++) begin
                        if (tbl_valid[i] && !marked[i]) begin
                            if (c.op == OP_KIND) begin
                                // falling significance, lower slot wins a tie
                                if (tbl_kind[i] == c.kind) begin
                                    key = longint'(tbl_sig[i]);
                                    if (best < 0 || key > bkey) begin
                                        best = i;
                                        bkey = key;
                                    end
                                end
                            end else begin
                                // nearest first, inside the radius only
                                key = dist_sq(i, c.px, c.py);
                                if (key <= r2 && (best < 0 || key < bkey)) begin
                                    best = i;
                                    bkey = key;
                                end
                            end
                        end
                    end
                    if (best < 0) break;
                    marked[best] = 1'b1;
                    a.found  = 1'b1;
                    a.stored = 1'b0;
                    a.kind   = tbl_kind[best];
                    a.x      = tbl_x[best];
                    a.y      = tbl_y[best];
                    a.stamp  = tbl_stamp[best];
                    a.sig    = tbl_sig[best];
                    a.last   = 1'b0;
                    expected_words = {expected_words, a};
                    n++;
                end
                if (n == 0) expected_words = {expected_words, empty_answer(1'b0)};
                else expected_words[expected_words.size() - 1].last = 1'b1;
            end
        endcase
    endfunction

    function automatic t_cmd make_cmd(logic [1:0] op);
        t_cmd c;
        c = '{default: '0};
        c.op = op;
        // Keep kinds and positions clustered so recalls find matches.
        c.kind = ($urandom_range(99) < 80) ? 8'($urandom_range(3)) : 8'($urandom);
        if ($urandom_range(99) < 75) begin
            c.px = 16'($signed($urandom_range(1600)) - 800);
            c.py = 16'($signed($urandom_range(1600)) - 800);
        end else begin
            c.px = 16'($urandom);
            c.py = 16'($urandom);
        end
        c.radius = ($urandom_range(99) < 70) ? 16'($urandom_range(900)) : 16'($urandom);
        if ($urandom_range(99) < 5) tick_now = $urandom;
        else tick_now = tick_now + 32'($urandom_range(40));
        c.tick  = tick_now;
        c.sig   = 24'($urandom);
        c.count = ($urandom_range(99) < 80) ? 5'($urandom_range(SLOTS)) : 5'($urandom);
        return c;
    endfunction

    function automatic void queue_cfg(logic idx, logic [23:0] val);
        t_cmd c;
        c = '{default: '0};
        c.is_cfg  = 1'b1;
        c.cfg_idx = idx;
        c.cfg_val = val;
        pending_cmds = {pending_cmds, c};
    endfunction

    function automatic void queue_random(int n);
        int   r;
        t_cmd c;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(99);
            if (r < 45) c = make_cmd(OP_ADD);
            else if (r < 65) c = make_cmd(OP_KIND);
            else if (r < 85) c = make_cmd(OP_NEAR);
            else c = make_cmd(OP_DECAY);
            pending_cmds = {pending_cmds, c};
        end
    endfunction

    // Driver: present commands and register writes, idle at random.
    always @(posedge i_clk) begin
        bit   launched;
        bit   cfg_done;
        bit   calm;
        t_cmd it;
        if (!i_rst_n) begin
            start <= 1'b0;
            i_cfg_valid <= 1'b0;
            quiet_cycles <= 0;
        end else begin
            launched = start && !busy;
            cfg_done = i_cfg_valid && o_cfg_ready;
            if (launched) begin
                predict_table(cur_cmd);
                words_sent++;
            end
            if (cfg_done) begin
                if (i_cfg_index == CFG_RATE) rate_q = i_cfg_data;
                else floor_q = i_cfg_data;
            end
            if (busy || start || o_valid || expected_words.size() != 0)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            calm = (words_sent >= 220 && words_sent < 320);
            // hold the current word until it is taken
            if ((!start || launched) && (!i_cfg_valid || cfg_done)) begin
                if (pending_cmds.size() == 0 || (!calm && $urandom_range(99) < 25)) begin
                    start <= 1'b0;
                    i_cfg_valid <= 1'b0;
                end else if (pending_cmds[0].is_cfg) begin
                    start <= 1'b0;
                    // write registers only once the table has gone quiet
                    if (quiet_cycles >= QUIET_MIN && !launched) begin
                        it = pending_cmds.pop_front();
                        i_cfg_index <= it.cfg_idx;
                        i_cfg_data  <= it.cfg_val;
                        i_cfg_valid <= 1'b1;
                    end else begin
                        i_cfg_valid <= 1'b0;
                    end
                end else begin
                    it = pending_cmds.pop_front();
                    cur_cmd = it;
                    i_opcode           <= it.op;
                    i_mem_kind         <= it.kind;
                    i_pos_x            <= it.px;
                    i_pos_y            <= it.py;
                    i_search_radius    <= it.radius;
                    i_now_tick         <= it.tick;
                    i_new_significance <= it.sig;
                    i_max_count        <= it.count;
                    start <= 1'b1;
                    i_cfg_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check every result word against the oldest prediction.
    always @(posedge i_clk) begin
        t_answer e;
        if (i_rst_n) begin
            if ((start && !busy) || o_valid || (i_cfg_valid && o_cfg_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WDOG_MAX) begin
                $display("significance_ranked_memory_table_top: mismatch");
                $finish;
            end
            if (o_valid) begin
                if (expected_words.size() == 0) begin
                    $error("result word with nothing expected");
                    fails++;
                end else begin
                    e = expected_words.pop_front();
                    if (o_found !== e.found) begin
                        $error("found: expected %0h, got %0h", e.found, o_found);
                        fails++;
                    end
                    if (o_stored !== e.stored) begin
                        $error("stored: expected %0h, got %0h", e.stored, o_stored);
                        fails++;
                    end
                    if (o_out_kind !== e.kind) begin
                        $error("out_kind: expected %0h, got %0h", e.kind, o_out_kind);
                        fails++;
                    end
                    if (o_out_x !== e.x) begin
                        $error("out_x: expected %0h, got %0h", e.x, o_out_x);
                        fails++;
                    end
                    if (o_out_y !== e.y) begin
                        $error("out_y: expected %0h, got %0h", e.y, o_out_y);
                        fails++;
                    end
                    if (o_out_stamp !== e.stamp) begin
                        $error("out_stamp: expected %0h, got %0h", e.stamp, o_out_stamp);
                        fails++;
                    end
                    if (o_out_significance !== e.sig) begin
                        $error("out_significance: expected %0h, got %0h",
                               e.sig, o_out_significance);
                        fails++;
                    end
                    if (o_last !== e.last) begin
                        $error("last: expected %0h, got %0h", e.last, o_last);
                        fails++;
                    end
                end
            end
        end
    end

    initial begin
        t_cmd c;
        fails = 0;
        stall_cycles = 0;
        words_sent = 0;
        tick_now = 32'd100;
        rate_q  = RATE_RST;
        floor_q = FLOOR_RST;
        tbl_valid = '{default: 1'b0};
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_RATE;
        i_cfg_data <= '0;
        i_opcode <= OP_ADD;
        i_mem_kind <= '0;
        i_pos_x <= '0;
        i_pos_y <= '0;
        i_search_radius <= '0;
        i_now_tick <= '0;
        i_new_significance <= '0;
        i_max_count <= '0;

        // Directed: recall on an empty table, then field extremes.
        c = make_cmd(OP_KIND);   c.count = 5'd16;               pending_cmds = {pending_cmds, c};
        c = make_cmd(OP_NEAR);   c.radius = 16'hFFFF;           pending_cmds = {pending_cmds, c};
        c = make_cmd(OP_DECAY);                                 pending_cmds = {pending_cmds, c};
        c = make_cmd(OP_ADD); c.kind = 8'hFF; c.px = 16'h8000; c.py = 16'h7FFF;
        c.sig = 24'hFFFFFF; c.tick = 32'hFFFFFFF0;              pending_cmds = {pending_cmds, c};
        c = make_cmd(OP_ADD); c.kind = 8'h00; c.px = 16'h7FFF; c.py = 16'h8000;
        c.sig = 24'h0;                                          pending_cmds = {pending_cmds, c};
        // equal significances to test the lower-slot tie rule
        for (int k = 0; k < 14; k++) begin
            c = make_cmd(OP_ADD); c.kind = 8'd1; c.sig = 24'h001000;
            pending_cmds = {pending_cmds, c};
        end
        // full table: equal significance dropped, greater replaces
        c = make_cmd(OP_ADD); c.sig = 24'h0;                    pending_cmds = {pending_cmds, c};
        c = make_cmd(OP_ADD); c.sig = 24'h000001; c.kind = 8'd1;
        pending_cmds = {pending_cmds, c};
        c = make_cmd(OP_KIND); c.kind = 8'd1; c.count = 5'd31;  pending_cmds = {pending_cmds, c};
        c = make_cmd(OP_KIND); c.kind = 8'd1; c.count = 5'd0;   pending_cmds = {pending_cmds, c};
        c = make_cmd(OP_NEAR); c.px = 16'h8000; c.py = 16'h8000;
        c.radius = 16'hFFFF; c.count = 5'd16;                   pending_cmds = {pending_cmds, c};
        c = make_cmd(OP_NEAR); c.radius = 16'd0; c.count = 5'd16;
        pending_cmds = {pending_cmds, c};
        // decay across the tick wrap
        c = make_cmd(OP_DECAY); c.tick = 32'd5;                 pending_cmds = {pending_cmds, c};

        queue_random(110);
        queue_cfg(CFG_RATE, 24'd0);
        queue_cfg(CFG_FLOOR, 24'd0);
        queue_random(90);
        queue_cfg(CFG_RATE, 24'hFFFFFF);
        queue_cfg(CFG_FLOOR, 24'hFFFFFF);
        queue_random(90);
        queue_cfg(CFG_RATE, 24'($urandom_range(200000)));
        queue_cfg(CFG_FLOOR, 24'($urandom));
        queue_random(90);
        queue_cfg(CFG_RATE, 24'($urandom_range(5000)));
        queue_cfg(CFG_FLOOR, 24'($urandom_range(3000)));
        queue_random(90);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // drain: all words sent, all results in, table quiet
        while (pending_cmds.size() != 0 || start || i_cfg_valid || busy
               || expected_words.size() != 0)
            @(posedge i_clk);
        repeat (4 * SLOTS) @(posedge i_clk);
        if (fails == 0 && expected_words.size() == 0)
            $display("significance_ranked_memory_table_top: match");
        else
            $display("significance_ranked_memory_table_top: mismatch");
        $finish;
    end

endmodule
